### hdl/swtc_pkg.sv
// Shared types, constants and the pulse template table for the sliding
// window template classifier. No dependencies.
`default_nettype none

package swtc_pkg;

    localparam int WIN_LEN   = 10;
    localparam int CLS_COUNT = 4;
    localparam int SAMPLE_W  = 10;
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int ERR_W     = 24;
    localparam int POS_W     = 4;
    localparam int CLS_W     = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SQ_W-1:0]     t_sq;
    typedef logic [ERR_W-1:0]    t_err;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [CLS_W-1:0]    t_cls;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_pos POS_LAST = POS_W'(WIN_LEN - 1);
    localparam t_pos FILL_MAX = POS_W'(WIN_LEN);

    // template classes
    localparam t_cls CLS_IDLE  = 2'd0;
    localparam t_cls CLS_PULSE = 2'd1;
    localparam t_cls CLS_HIGH  = 2'd2;
    localparam t_cls CLS_MID   = 2'd3;
    localparam t_cls CLS_LAST  = CLS_W'(CLS_COUNT - 1);

    // configuration register indexes
    localparam t_cfg_idx CFG_IDLE_LEVEL = 2'd0;
    localparam t_cfg_idx CFG_HIGH_LEVEL = 2'd1;
    localparam t_cfg_idx CFG_MID_LEVEL  = 2'd2;

    localparam t_sample IDLE_LEVEL_RST = 10'd400;
    localparam t_sample HIGH_LEVEL_RST = 10'd900;
    localparam t_sample MID_LEVEL_RST  = 10'd800;

    // controller -> datapath commands
    typedef struct packed {
        logic shift;     // push accepted sample into window
        logic issue;     // one element of the sweep enters the pipe
        logic first;     // first element of a class
        logic last;      // last element of a class
        t_cls cls;
        t_pos pos;
        logic load_out;  // copy best match into output register
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic busy;      // elements still in flight
    } t_dp_sts;

    // fixed pulse shape, oldest position first
    function automatic t_sample pulse_at(input t_pos pos);
        t_sample v;
        case (pos)
            4'd0:    v = 10'd321;
            4'd1:    v = 10'd327;
            4'd2:    v = 10'd427;
            4'd3:    v = 10'd775;
            4'd4:    v = 10'd1000;
            4'd5:    v = 10'd1000;
            4'd6:    v = 10'd833;
            4'd7:    v = 10'd598;
            4'd8:    v = 10'd473;
            4'd9:    v = 10'd396;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/swtc_sample_if.sv
// Input stream interface: one sample per transaction.
// Depends on swtc_pkg.
`default_nettype none

interface swtc_sample_if;
    logic              valid;
    logic              ready;
    swtc_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### hdl/swtc_result_if.sv
// Output stream interface: one classification result per transaction.
// Depends on swtc_pkg.
`default_nettype none

interface swtc_result_if;
    logic           valid;
    logic           ready;
    swtc_pkg::t_cls best_class;
    swtc_pkg::t_err best_error;
    logic           window_full;

    modport source (output valid, output best_class, output best_error,
                    output window_full, input ready);
    modport sink   (input valid, input best_class, input best_error,
                    input window_full, output ready);
endinterface

`default_nettype wire

### hdl/sliding_window_template_classifier.sv
// Top level of the sliding window template classifier: controller,
// datapath and stream interfaces. Depends on swtc_pkg, swtc_sample_if,
// swtc_result_if, swtc_ctrl and swtc_dp.
`default_nettype none

// Each accepted sample is pushed into a ten-deep window (oldest dropped),
// then the window is scored against four templates by sum of squared
// differences: class 0, 2 and 3 are flat levels from the idle, high and mid
// level registers, class 1 is a fixed pulse shape. The result carries the
// best class (ties go to the lower class), its error and window_full, which
// goes high once ten samples have been taken; before that, unfilled slots
// count as zero. One result transaction per sample transaction.
// Timing: the sweep uses a single subtract/square/accumulate unit, one
// window element per cycle, over every class and position; then the pipe
// drains, the result is loaded, and only then can the next sample be taken,
// as long as the result side keeps up.
// The output register holds a finished result while the next sample is
// being worked; a sweep only stalls at its end if that result is still
// waiting. Level registers may be written whenever the block is idle;
// index 3 is ignored.

module sliding_window_template_classifier (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    swtc_sample_if.sink                i_in,
    swtc_result_if.source              o_out,
    input  wire logic                  i_cfg_we,
    input  wire swtc_pkg::t_cfg_idx    i_cfg_idx,
    input  wire swtc_pkg::t_sample     i_cfg_data
);

    swtc_pkg::t_dp_cmd w_cmd;
    swtc_pkg::t_dp_sts w_sts;
    logic              w_in_ready;
    logic              w_out_valid;
    swtc_pkg::t_cls    w_best_class;
    swtc_pkg::t_err    w_best_error;
    logic              w_window_full;

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = w_out_valid;
    assign o_out.best_class  = w_best_class;
    assign o_out.best_error  = w_best_error;
    assign o_out.window_full = w_window_full;

    swtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    swtc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_sample      (i_in.sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_best_class  (w_best_class),
        .o_best_error  (w_best_error),
        .o_window_full (w_window_full)
    );

    // a sweep starts right after a sample transaction, at class 0 position 0
    a_sweep_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.shift |=> (w_cmd.issue && w_cmd.first && w_cmd.cls == swtc_pkg::CLS_IDLE))
        else $error("sweep did not start after sample transaction");

    // nothing is issued after the last element of the last class
    a_sweep_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.issue && w_cmd.last && w_cmd.cls == swtc_pkg::CLS_LAST) |=> !w_cmd.issue)
        else $error("issue continued past end of sweep");

    // result is loaded only once the pipe is empty
    a_load_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !w_sts.busy)
        else $error("result loaded with elements in flight");

    // a waiting result is never overwritten
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out.valid || o_out.ready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### hdl/swtc_ctrl.sv
// Controller: accepts a sample, sweeps class x position, waits for the
// pipe to drain and loads the output register. Depends on swtc_pkg.
`default_nettype none

module swtc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output swtc_pkg::t_dp_cmd      o_cmd,
    input  wire swtc_pkg::t_dp_sts i_sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]     r_state, n_state;
    swtc_pkg::t_cls r_cls, n_cls;
    swtc_pkg::t_pos r_pos, n_pos;
    logic           r_out_valid, n_out_valid;
    logic           w_accept;
    logic           w_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = (r_state == S_DRAIN) && !i_sts.busy
                         && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.shift    = w_accept;
        o_cmd.issue    = (r_state == S_RUN);
        o_cmd.first    = (r_pos == '0);
        o_cmd.last     = (r_pos == swtc_pkg::POS_LAST);
        o_cmd.cls      = r_cls;
        o_cmd.pos      = r_pos;
        o_cmd.load_out = w_load;
    end

    always_comb begin
        n_state     = r_state;
        n_cls       = r_cls;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                    n_cls   = '0;
                    n_pos   = '0;
                end
            end
            S_RUN: begin
                if (r_pos == swtc_pkg::POS_LAST) begin
                    n_pos = '0;
                    if (r_cls == swtc_pkg::CLS_LAST) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_cls = r_cls + 1'b1;
                    end
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_DRAIN: begin
                if (w_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cls       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cls       <= n_cls;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### hdl/swtc_dp.sv
// Datapath: sample window, level registers, three-stage squared
// difference pipe, best-match tracking and output register. Depends on swtc_pkg.
`default_nettype none

module swtc_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire swtc_pkg::t_dp_cmd    i_cmd,
    output swtc_pkg::t_dp_sts         o_sts,
    input  wire swtc_pkg::t_sample    i_sample,
    input  wire logic                 i_cfg_we,
    input  wire swtc_pkg::t_cfg_idx   i_cfg_idx,
    input  wire swtc_pkg::t_sample    i_cfg_data,
    output swtc_pkg::t_cls            o_best_class,
    output swtc_pkg::t_err            o_best_error,
    output logic                      o_window_full
);

    swtc_pkg::t_sample r_win [swtc_pkg::WIN_LEN];
    swtc_pkg::t_pos    r_fill;
    swtc_pkg::t_sample r_idle_lvl, r_high_lvl, r_mid_lvl;

    // stage A: absolute difference
    logic              r_a_vld, r_a_first, r_a_last;
    swtc_pkg::t_cls    r_a_cls;
    swtc_pkg::t_sample r_a_diff;
    // stage B: square
    logic              r_b_vld, r_b_first, r_b_last;
    swtc_pkg::t_cls    r_b_cls;
    swtc_pkg::t_sq     r_b_sq;
    // stage C: accumulate and compare
    swtc_pkg::t_err    r_acc, n_acc;
    swtc_pkg::t_err    r_best_err;
    swtc_pkg::t_cls    r_best_cls;
    // output register
    swtc_pkg::t_cls    r_out_cls;
    swtc_pkg::t_err    r_out_err;
    logic              r_out_full;

    swtc_pkg::t_sample w_elem, w_tmpl, w_diff;

    assign o_sts.busy    = r_a_vld || r_b_vld;
    assign o_best_class  = r_out_cls;
    assign o_best_error  = r_out_err;
    assign o_window_full = r_out_full;

    // window shift and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < swtc_pkg::WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_fill <= '0;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < swtc_pkg::WIN_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[swtc_pkg::WIN_LEN-1] <= i_sample;
            if (r_fill != swtc_pkg::FILL_MAX) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // level registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_lvl <= swtc_pkg::IDLE_LEVEL_RST;
            r_high_lvl <= swtc_pkg::HIGH_LEVEL_RST;
            r_mid_lvl  <= swtc_pkg::MID_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swtc_pkg::CFG_IDLE_LEVEL: r_idle_lvl <= i_cfg_data;
                swtc_pkg::CFG_HIGH_LEVEL: r_high_lvl <= i_cfg_data;
                swtc_pkg::CFG_MID_LEVEL:  r_mid_lvl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_elem = r_win[i_cmd.pos];
        case (i_cmd.cls)
            swtc_pkg::CLS_IDLE:  w_tmpl = r_idle_lvl;
            swtc_pkg::CLS_PULSE: w_tmpl = swtc_pkg::pulse_at(i_cmd.pos);
            swtc_pkg::CLS_HIGH:  w_tmpl = r_high_lvl;
            default:             w_tmpl = r_mid_lvl;
        endcase
        w_diff = (w_elem >= w_tmpl) ? (w_elem - w_tmpl) : (w_tmpl - w_elem);
    end

    always_comb begin
        n_acc = (r_b_first ? '0 : r_acc) + swtc_pkg::ERR_W'(r_b_sq);
    end

    // pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.issue;
            r_b_vld <= r_a_vld;
        end
    end

    // pipe payload
    always_ff @(posedge i_clk) begin
        r_a_diff  <= w_diff;
        r_a_first <= i_cmd.first;
        r_a_last  <= i_cmd.last;
        r_a_cls   <= i_cmd.cls;

        // full-width product
        r_b_sq    <= {{swtc_pkg::SAMPLE_W{1'b0}}, r_a_diff}
                     * {{swtc_pkg::SAMPLE_W{1'b0}}, r_a_diff};
        r_b_first <= r_a_first;
        r_b_last  <= r_a_last;
        r_b_cls   <= r_a_cls;

        if (r_b_vld) begin
            r_acc <= n_acc;
            // first class always wins; later ones only when strictly smaller
            if (r_b_last && (r_b_cls == swtc_pkg::CLS_IDLE || n_acc < r_best_err)) begin
                r_best_err <= n_acc;
                r_best_cls <= r_b_cls;
            end
        end

        if (i_cmd.load_out) begin
            r_out_cls  <= r_best_cls;
            r_out_err  <= r_best_err;
            r_out_full <= (r_fill == swtc_pkg::FILL_MAX);
        end
    end

endmodule

`default_nettype wire
